@@ hw/rtl/cft_pkg.sv @@
`timescale 1ns / 1ps

package cft_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] DELIM_RESET = 8'h2C;
    localparam logic [7:0] QUOTE_RESET = 8'h22;
    localparam logic DQ_MODE_RESET = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_DELIM = 2'd0;
    localparam logic [1:0] REG_QUOTE = 2'd1;
    localparam logic [1:0] REG_DQ_MODE = 2'd2;

    typedef enum logic [4:0] {
        ST_ROW    = 5'b00001,
        ST_FIELD  = 5'b00010,
        ST_QUOTED = 5'b00100,
        ST_QQ     = 5'b01000,
        ST_UNQ    = 5'b10000
    } t_state;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [7:0] quote_char;
        logic       double_quote_mode;
    } t_cfg;

    typedef struct packed {
        logic       row_open;
        logic       field_open;
        logic       char_valid;
        logic [7:0] out_char;
        logic       row_done;
    } t_tok;

endpackage

@@ hw/rtl/cft_if.sv @@
`timescale 1ns / 1ps

// character stream channel
interface cft_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source(output valid, output char_in, input ready);
    modport sink(input valid, input char_in, output ready);
endinterface

// token flag channel
interface cft_tok_if;
    logic          valid;
    logic          ready;
    cft_pkg::t_tok tok;

    modport source(output valid, output tok, input ready);
    modport sink(input valid, input tok, output ready);
endinterface

@@ hw/rtl/cft_in_reg.sv @@
`timescale 1ns / 1ps

module cft_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    output logic       o_ready,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_char
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       n_valid;

    // load when empty or when the held character moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

@@ hw/rtl/cft_step.sv @@
`timescale 1ns / 1ps

module cft_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic [7:0]    i_char,
    input  cft_pkg::t_cfg i_cfg,
    output cft_pkg::t_tok o_tok
);

    cft_pkg::t_state r_state;
    cft_pkg::t_state n_state;
    logic is_q;
    logic is_d;
    logic is_lf;
    logic ro;
    logic fo;
    logic cv;
    logic rd;

    assign is_q  = (i_char == i_cfg.quote_char);
    assign is_d  = (i_char == i_cfg.delimiter_char);
    assign is_lf = (i_char == cft_pkg::CH_LF);

    // quote beats delimiter beats LF; CR leaves everything untouched
    always_comb begin
        n_state = r_state;
        ro = 1'b0;
        fo = 1'b0;
        cv = 1'b0;
        rd = 1'b0;
        if (i_char != cft_pkg::CH_CR) begin
            unique case (r_state)
                cft_pkg::ST_FIELD: begin
                    if (is_q) begin
                        n_state = cft_pkg::ST_QUOTED;
                    end else if (is_d) begin
                        fo = 1'b1;
                    end else if (is_lf) begin
                        rd = 1'b1;
                        n_state = cft_pkg::ST_ROW;
                    end else begin
                        cv = 1'b1;
                        n_state = cft_pkg::ST_UNQ;
                    end
                end
                cft_pkg::ST_QUOTED: begin
                    if (is_q) begin
                        n_state = i_cfg.double_quote_mode ? cft_pkg::ST_QQ : cft_pkg::ST_UNQ;
                    end else begin
                        cv = 1'b1;
                    end
                end
                cft_pkg::ST_QQ: begin
                    if (is_q) begin
                        cv = 1'b1;
                        n_state = cft_pkg::ST_QUOTED;
                    end else if (is_d) begin
                        fo = 1'b1;
                        n_state = cft_pkg::ST_FIELD;
                    end else if (is_lf) begin
                        rd = 1'b1;
                        n_state = cft_pkg::ST_ROW;
                    end else begin
                        cv = 1'b1;
                        n_state = i_cfg.double_quote_mode ? cft_pkg::ST_UNQ
                                                          : cft_pkg::ST_QUOTED;
                    end
                end
                cft_pkg::ST_UNQ: begin
                    if (is_d) begin
                        fo = 1'b1;
                        n_state = cft_pkg::ST_FIELD;
                    end else if (is_lf) begin
                        rd = 1'b1;
                        n_state = cft_pkg::ST_ROW;
                    end else begin
                        cv = 1'b1;
                    end
                end
                default: begin
                    // row start; LF here gives an empty row with no field
                    ro = 1'b1;
                    if (is_q) begin
                        fo = 1'b1;
                        n_state = cft_pkg::ST_QUOTED;
                    end else if (is_d) begin
                        fo = 1'b1;
                        n_state = cft_pkg::ST_FIELD;
                    end else if (is_lf) begin
                        n_state = cft_pkg::ST_ROW;
                    end else begin
                        fo = 1'b1;
                        cv = 1'b1;
                        n_state = cft_pkg::ST_UNQ;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cft_pkg::ST_ROW;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

    assign o_tok.row_open   = ro;
    assign o_tok.field_open = fo;
    assign o_tok.char_valid = cv;
    assign o_tok.out_char   = cv ? i_char : 8'h00;
    assign o_tok.row_done   = rd;

endmodule

@@ hw/rtl/csv_field_tokenizer_unit.sv @@
`timescale 1ns / 1ps

// Channel      Dir  Modport  Payload
// i_char_chan  in   sink     char_in [7:0]
// o_tok_chan   out  source   row_open, field_open, char_valid, out_char [7:0], row_done
// cfg write    in   -        i_cfg_we, i_cfg_idx [1:0], i_cfg_data [7:0]
//
// One character per cycle sustained while the result side takes tokens; a result
// is offered once it has passed the input register, then the result register.
// The tokenizer state register advances as a character leaves the input
// register; its update is a handful of 8-bit compares.
// Synchronous active-low reset: both stages empty, state at row start,
// registers at ',' '"' and doubled-quote mode on.
// A stalled result holds in the result register while the input register
// still takes one more character; backpressure then reaches i_char_chan.ready.

module csv_field_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cft_char_if.sink   i_char_chan,
    cft_tok_if.source  o_tok_chan,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    cft_pkg::t_cfg r_cfg;
    cft_pkg::t_tok r_tok;
    cft_pkg::t_tok step_tok;
    logic          r_out_valid;
    logic          out_free;
    logic          adv;
    logic          in_valid;
    logic [7:0]    in_char;
    logic          in_ready;

    // config registers; index 3 is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_char    <= cft_pkg::DELIM_RESET;
            r_cfg.quote_char        <= cft_pkg::QUOTE_RESET;
            r_cfg.double_quote_mode <= cft_pkg::DQ_MODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cft_pkg::REG_DELIM:   r_cfg.delimiter_char    <= i_cfg_data;
                cft_pkg::REG_QUOTE:   r_cfg.quote_char        <= i_cfg_data;
                cft_pkg::REG_DQ_MODE: r_cfg.double_quote_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // result register can take a new token when empty or being drained
    assign out_free = !r_out_valid || o_tok_chan.ready;
    assign adv      = in_valid && out_free;

    cft_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_char_chan.valid),
        .i_char  (i_char_chan.char_in),
        .o_ready (in_ready),
        .i_take  (out_free),
        .o_valid (in_valid),
        .o_char  (in_char)
    );

    assign i_char_chan.ready = in_ready;

    cft_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_char  (in_char),
        .i_cfg   (r_cfg),
        .o_tok   (step_tok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_valid;
        end
    end

    // payload only moves on a real advance
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tok <= step_tok;
        end
    end

    assign o_tok_chan.valid = r_out_valid;
    assign o_tok_chan.tok   = r_tok;

endmodule

@@ hw/rtl/cft_checker.sv @@
`timescale 1ns / 1ps

module cft_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input cft_pkg::t_tok i_tok
);

    // a stalled token stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("token dropped while stalled");

    // result stage is empty the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("token valid after reset");

    // an appended character is never also a row end, and row end never opens a row
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_tok.row_done && (i_tok.char_valid || i_tok.row_open)))
        else $error("conflicting token flags");

    // data byte is zero when nothing is appended
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_tok.char_valid |-> i_tok.out_char == 8'h00)
        else $error("stray character on token");

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tok_chan.valid),
    .i_out_ready (o_tok_chan.ready),
    .i_tok       (o_tok_chan.tok)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    // no transfer on either channel for this many cycles means a hang
    localparam int QUIET_LIMIT = 2000;
    // random items per phase; six phases
    localparam int PHASE_ITEMS = 270;

    // Models the tokenizer: tracks its own parse state and register copy.
    // Each accepted character produces exactly one token flag set.
    class token_scoreboard;
        cft_pkg::t_state parse_st;
        cft_pkg::t_cfg   regs;
        cft_pkg::t_tok   pending_tokens[$];
        int              errors;

        function new();
            parse_st = cft_pkg::ST_ROW;
            regs.delimiter_char = cft_pkg::DELIM_RESET;
            regs.quote_char = cft_pkg::QUOTE_RESET;
            regs.double_quote_mode = cft_pkg::DQ_MODE_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                cft_pkg::REG_DELIM:   regs.delimiter_char = data;
                cft_pkg::REG_QUOTE:   regs.quote_char = data;
                cft_pkg::REG_DQ_MODE: regs.double_quote_mode = data[0];
                default: ;
            endcase
        endfunction

        // works out the token for one accepted character
        function void note_char(logic [7:0] c);
            cft_pkg::t_tok tk;
            logic is_quote;
            logic is_delim;
            logic is_lf;
            tk = '0;
            is_quote = (c == regs.quote_char);
            is_delim = (c == regs.delimiter_char);
            is_lf = (c == cft_pkg::CH_LF);
            // CR is dropped outright, ahead of any other compare
            if (c != cft_pkg::CH_CR) begin
                case (parse_st)
                    cft_pkg::ST_FIELD: begin
                        if (is_quote) parse_st = cft_pkg::ST_QUOTED;
                        else if (is_delim) tk.field_open = 1'b1;
                        else if (is_lf) begin
                            tk.row_done = 1'b1;
                            parse_st = cft_pkg::ST_ROW;
                        end else begin
                            tk.char_valid = 1'b1;
                            parse_st = cft_pkg::ST_UNQ;
                        end
                    end
                    cft_pkg::ST_QUOTED: begin
                        if (is_quote) begin
                            if (regs.double_quote_mode) parse_st = cft_pkg::ST_QQ;
                            else parse_st = cft_pkg::ST_UNQ;
                        end else begin
                            tk.char_valid = 1'b1;
                        end
                    end
                    cft_pkg::ST_QQ: begin
                        if (is_quote) begin
                            tk.char_valid = 1'b1;
                            parse_st = cft_pkg::ST_QUOTED;
                        end else if (is_delim) begin
                            tk.field_open = 1'b1;
                            parse_st = cft_pkg::ST_FIELD;
                        end else if (is_lf) begin
                            tk.row_done = 1'b1;
                            parse_st = cft_pkg::ST_ROW;
                        end else begin
                            tk.char_valid = 1'b1;
                            // mode may have been switched off while here
                            if (regs.double_quote_mode) parse_st = cft_pkg::ST_UNQ;
                            else parse_st = cft_pkg::ST_QUOTED;
                        end
                    end
                    cft_pkg::ST_UNQ: begin
                        if (is_delim) begin
                            tk.field_open = 1'b1;
                            parse_st = cft_pkg::ST_FIELD;
                        end else if (is_lf) begin
                            tk.row_done = 1'b1;
                            parse_st = cft_pkg::ST_ROW;
                        end else begin
                            tk.char_valid = 1'b1;
                        end
                    end
                    default: begin
                        // row start: anything but CR opens a row
                        tk.row_open = 1'b1;
                        if (is_quote) begin
                            tk.field_open = 1'b1;
                            parse_st = cft_pkg::ST_QUOTED;
                        end else if (is_delim) begin
                            tk.field_open = 1'b1;
                            parse_st = cft_pkg::ST_FIELD;
                        end else if (is_lf) begin
                            parse_st = cft_pkg::ST_ROW;
                        end else begin
                            tk.field_open = 1'b1;
                            tk.char_valid = 1'b1;
                            parse_st = cft_pkg::ST_UNQ;
                        end
                    end
                endcase
            end
            if (tk.char_valid) tk.out_char = c;
            pending_tokens = {pending_tokens, tk};
        endfunction

        function void cmp(string what, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_tok(cft_pkg::t_tok got);
            cft_pkg::t_tok want;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual %0h",
                         $time, got);
                errors++;
            end else begin
                want = pending_tokens.pop_front();
                cmp("row_open", 8'(want.row_open), 8'(got.row_open));
                cmp("field_open", 8'(want.field_open), 8'(got.field_open));
                cmp("char_valid", 8'(want.char_valid), 8'(got.char_valid));
                cmp("out_char", want.out_char, got.out_char);
                cmp("row_done", 8'(want.row_done), 8'(got.row_done));
            end
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        function void check_leftover();
            if (pending_tokens.size() != 0) begin
                $display("%0t: tokens missing, expected %0d more, actual 0",
                         $time, pending_tokens.size());
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [7:0] cfg_data;

    cft_char_if char_ch();
    cft_tok_if  tok_ch();

    token_scoreboard sb = new();

    int src_idle_pct;
    int snk_idle_pct;
    int n_sent;

    csv_field_tokenizer_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_char_chan(char_ch),
        .o_tok_chan (tok_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: ready toggles on the falling edge, tokens are taken on the
    // rising edge whenever a transfer happens.
    always @(negedge clk) begin
        tok_ch.ready = ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && tok_ch.valid && tok_ch.ready) sb.check_tok(tok_ch.tok);
    end

    // Hang guard: counts cycles without a transfer on either channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((char_ch.valid && char_ch.ready) || (tok_ch.valid && tok_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // One character transfer; the sender may idle a random number of cycles
    // first. Valid is left high on return so back-to-back items run at full rate.
    task automatic send_char(input logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            char_ch.valid = 1'b0;
            @(negedge clk);
        end
        char_ch.valid = 1'b1;
        char_ch.char_in = c;
        @(posedge clk);
        while (!char_ch.ready) @(posedge clk);
        sb.note_char(c);
        n_sent++;
    endtask

    // Stop sending and wait for every outstanding token.
    task automatic drain();
        @(negedge clk);
        char_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Register write; only called with the pipeline empty.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // a field byte that is none of the current special characters
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == sb.regs.delimiter_char || c == sb.regs.quote_char ||
               c == cft_pkg::CH_LF || c == cft_pkg::CH_CR);
        return c;
    endfunction

    // random byte biased towards the characters that steer the parser
    function automatic logic [7:0] noisy_char();
        case ($urandom_range(9))
            0: return sb.regs.delimiter_char;
            1: return sb.regs.quote_char;
            2: return cft_pkg::CH_LF;
            3: return cft_pkg::CH_CR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One well-formed row: empty, bare and quoted fields, the quoted ones with
    // doubled quotes, delimiters and line feeds inside; CRLF or LF ending.
    task automatic send_record();
        int nfields;
        int nchars;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0) send_char(sb.regs.delimiter_char);
            case ($urandom_range(2))
                0: ;
                1: begin
                    nchars = $urandom_range(1, 5);
                    repeat (nchars) send_char(plain_char());
                end
                default: begin
                    nchars = $urandom_range(0, 5);
                    send_char(sb.regs.quote_char);
                    repeat (nchars) begin
                        case ($urandom_range(7))
                            0: begin
                                send_char(sb.regs.quote_char);
                                send_char(sb.regs.quote_char);
                            end
                            1: send_char(sb.regs.delimiter_char);
                            2: send_char(cft_pkg::CH_LF);
                            default: send_char(plain_char());
                        endcase
                    end
                    send_char(sb.regs.quote_char);
                end
            endcase
        end
        if ($urandom_range(3) == 0) send_char(cft_pkg::CH_CR);
        send_char(cft_pkg::CH_LF);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) send_char(noisy_char());
    endtask

    initial begin : stimulus
        logic [7:0] opening[$];
        int         target;
        bit         paused;
        logic       dq;

        // Walks the states on reset settings: dropped CR, blank row, delimiter
        // at row start, LF and delimiter inside quotes, doubled quote, quote in
        // a bare field, byte extremes.
        opening = {cft_pkg::CH_CR, cft_pkg::CH_LF, cft_pkg::DELIM_RESET,
                   cft_pkg::DELIM_RESET, cft_pkg::QUOTE_RESET, cft_pkg::CH_LF,
                   cft_pkg::DELIM_RESET, cft_pkg::CH_CR, cft_pkg::QUOTE_RESET,
                   cft_pkg::QUOTE_RESET, cft_pkg::QUOTE_RESET,
                   8'h78, 8'hFF, 8'h00, cft_pkg::DELIM_RESET, cft_pkg::CH_LF,
                   8'h61, cft_pkg::CH_LF,
                   cft_pkg::QUOTE_RESET, cft_pkg::QUOTE_RESET, cft_pkg::DELIM_RESET,
                   8'h7A, cft_pkg::QUOTE_RESET, cft_pkg::CH_LF};

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = cft_pkg::REG_DELIM;
        cfg_data = '0;
        char_ch.valid = 1'b0;
        char_ch.char_in = '0;
        src_idle_pct = 17;
        snk_idle_pct = 66;
        n_sent = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (opening[i]) send_char(opening[i]);

        // Doubled-quote mode switched off while a closing quote is pending:
        // the next byte is data and the field stays quoted.
        send_char(cft_pkg::QUOTE_RESET);
        send_char(8'h61);
        send_char(cft_pkg::QUOTE_RESET);
        drain();
        write_reg(cft_pkg::REG_DQ_MODE, 8'h00);
        send_char(8'h62);
        send_char(cft_pkg::QUOTE_RESET);     // closes straight to a bare field now
        send_char(cft_pkg::DELIM_RESET);
        send_char(cft_pkg::QUOTE_RESET);
        send_char(cft_pkg::QUOTE_RESET);
        send_char(cft_pkg::CH_LF);
        // same pending quote, followed by a delimiter instead
        drain();
        write_reg(cft_pkg::REG_DQ_MODE, 8'h01);
        send_char(cft_pkg::QUOTE_RESET);
        send_char(cft_pkg::QUOTE_RESET);
        drain();
        write_reg(cft_pkg::REG_DQ_MODE, 8'h00);
        send_char(cft_pkg::DELIM_RESET);
        send_char(cft_pkg::CH_LF);

        // Random phases: two per idling profile, each with its own settings,
        // extremes and clashing characters among them.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    src_idle_pct = 17;
                    snk_idle_pct = 66;
                end
                1: begin
                    src_idle_pct = 66;
                    snk_idle_pct = 17;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            drain();
            case (ph)
                0: begin
                    write_reg(cft_pkg::REG_DELIM, cft_pkg::DELIM_RESET);
                    write_reg(cft_pkg::REG_QUOTE, cft_pkg::QUOTE_RESET);
                    write_reg(cft_pkg::REG_DQ_MODE, 8'h01);
                end
                1: begin
                    write_reg(cft_pkg::REG_DELIM, 8'h00);
                    write_reg(cft_pkg::REG_QUOTE, 8'hFF);
                    write_reg(cft_pkg::REG_DQ_MODE, 8'h00);
                end
                2: begin
                    write_reg(cft_pkg::REG_DELIM, 8'hFF);
                    write_reg(cft_pkg::REG_QUOTE, 8'h00);
                    write_reg(cft_pkg::REG_DQ_MODE, 8'h01);
                end
                3: begin
                    // quote and delimiter equal: the quote compare wins, but a bare field checks only the delimiter
                    write_reg(cft_pkg::REG_DELIM, 8'h3B);
                    write_reg(cft_pkg::REG_QUOTE, 8'h3B);
                    write_reg(cft_pkg::REG_DQ_MODE, 8'h01);
                end
                4: begin
                    // delimiter is LF, quote is CR and therefore never seen
                    write_reg(cft_pkg::REG_DELIM, cft_pkg::CH_LF);
                    write_reg(cft_pkg::REG_QUOTE, cft_pkg::CH_CR);
                    write_reg(cft_pkg::REG_DQ_MODE, 8'h00);
                end
                default: begin
                    // quote is LF, so LF can end a row only from a bare field
                    dq = 1'($urandom_range(1));
                    write_reg(cft_pkg::REG_DELIM, 8'($urandom_range(255)));
                    write_reg(cft_pkg::REG_QUOTE, cft_pkg::CH_LF);
                    write_reg(cft_pkg::REG_DQ_MODE, {7'b0, dq});
                end
            endcase

            target = n_sent + PHASE_ITEMS;
            paused = 1'b0;
            while (n_sent < target) begin
                // halfway through, hold off until the result side is empty
                if (!paused && n_sent >= target - PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(4) == 0) send_noise();
                else send_record();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        sb.check_leftover();

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
